// ----- sv/pstq_pkg.sv -----
// Shared types and constants for the process state table with device queues.
package pstq_pkg;

   localparam int unsigned CMD_W = 3;
   localparam int unsigned PID_W = 4;
   localparam int unsigned DEV_W = 2;
   localparam int unsigned PST_W = 3;
   localparam int unsigned KIND_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INIT      = 3'd0,
      CMD_REQUEST   = 3'd1,
      CMD_DISPATCH  = 3'd2,
      CMD_TIMEOUT   = 3'd3,
      CMD_SWAP_OUT  = 3'd4,
      CMD_SWAP_IN   = 3'd5,
      CMD_INTERRUPT = 3'd6,
      CMD_TERMINATE = 3'd7
   } cmd_type;

   localparam logic [PST_W-1:0] PS_NEW          = 3'd0;
   localparam logic [PST_W-1:0] PS_READY        = 3'd1;
   localparam logic [PST_W-1:0] PS_RUNNING      = 3'd2;
   localparam logic [PST_W-1:0] PS_BLOCKED      = 3'd3;
   localparam logic [PST_W-1:0] PS_READY_SUSP   = 3'd4;
   localparam logic [PST_W-1:0] PS_BLOCKED_SUSP = 3'd5;
   localparam logic [PST_W-1:0] PS_EXIT         = 3'd6;

   localparam logic [DEV_W-1:0] DEV_DISK     = 2'd0;
   localparam logic [DEV_W-1:0] DEV_PRINTER  = 2'd1;
   localparam logic [DEV_W-1:0] DEV_KEYBOARD = 2'd2;
   localparam logic [DEV_W-1:0] DEV_NONE     = 2'd3;

   localparam logic [KIND_W-1:0] KIND_PROC = 2'd0;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_READ,
      SQ_EXEC,
      SQ_RM,
      SQ_DP,
      SQ_DQ
   } seq_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [PID_W-1:0] proc_id;
      logic [DEV_W-1:0] device;
      logic [PST_W-1:0] init_state;
      logic             end_of_line;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [PID_W-1:0]  out_proc;
      logic [PST_W-1:0]  out_state;
      logic              changed;
      logic              last;
   } rsp_type;

endpackage

// ----- sv/pstq_ram.sv -----
// Simple dual-port synchronous memory with a registered read port.
module pstq_ram #(
   parameter int unsigned WIDTH = 6,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- sv/process_state_table_with_io_queues.sv -----
// Top level: process state table and device wait queues with a sequencer.
//
// One item is an event for one process: init, request, dispatch, timeout,
// swap out, swap in, interrupt or terminate. An item is taken when start is
// high and busy is low. Busy stays high until the item's work and any dump
// it asked for are done and the final result has left the output register.
// An event passes through the accepting cycle, the state memory read, and
// the update and write back; the next item can be taken in the cycle after.
// An interrupt then compacts the three queues in the queue memory, dropping
// the entries of its process. With end_of_line set, a dump follows: a pass
// over the state memory, then one over each queue, one result per valid
// process and per queue entry, each on rsp_item for one cycle with
// rsp_strobe high and last set on the final one. The receiver cannot stall,
// so results leave as they are read.
// Process and snapshot states live in one memory, queue entries in another;
// valid bits and queue lengths are flip-flops cleared by reset, so reset
// needs no clearing pass and the block is ready the cycle after it.
module process_state_table_with_io_queues #(
   parameter int unsigned NUM_PROCS   = 16,
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pstq_pkg::req_type req_item,
   output logic             rsp_strobe,
   output pstq_pkg::rsp_type rsp_item
);
   import pstq_pkg::*;

   localparam int unsigned PIW = $clog2(NUM_PROCS);
   localparam int unsigned QIW = $clog2(QUEUE_DEPTH);
   localparam int unsigned LW  = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned NPW = $clog2(NUM_PROCS + 1);
   localparam int unsigned CW  = (NPW > LW) ? NPW : LW;
   localparam int unsigned QAW = QIW + 2;
   localparam int unsigned EXW = (CW > PID_W + 1) ? CW : PID_W + 1;

   seq_type              seq_ff, seq_in;
   req_type              req_ff, req_in;
   logic [NUM_PROCS-1:0] valid_ff, valid_in;
   logic [LW-1:0]        lens_ff [3];
   logic [LW-1:0]        lens_in [3];
   logic [CW-1:0]        cnt_ff, cnt_in, wcnt_ff, wcnt_in;
   logic [1:0]           q_ff, q_in, pq_ff, pq_in;
   logic                 pend_ff, pend_in;
   logic [CW-1:0]        pidx_ff, pidx_in;
   logic                 strobe_ff, strobe_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 st_wr_en, st_rd_en;
   logic [PIW-1:0]       st_wr_addr, st_rd_addr;
   logic [2*PST_W-1:0]   st_wr_data, st_rd_data;
   logic                 qm_wr_en, qm_rd_en;
   logic [QAW-1:0]       qm_wr_addr, qm_rd_addr;
   logic [PID_W-1:0]     qm_wr_data, qm_rd_data;

   logic [EXW-1:0]       pid_ext;
   logic [PIW-1:0]       pid_addr;
   logic                 pid_ok;
   logic [1:0]           dev_q;
   logic [CW-1:0]        cur_len;
   logic [PST_W-1:0]     cur_st, cur_snap, new_st, init_st;
   logic [NUM_PROCS-1:0] later_valid;
   logic                 queues_empty, later_q_empty;

   pstq_ram #(.WIDTH(2*PST_W), .DEPTH(NUM_PROCS)) u_state_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   pstq_ram #(.WIDTH(PID_W), .DEPTH(4 << QIW)) u_queue_ram (
      .clock   (clock),
      .wr_en   (qm_wr_en),
      .wr_addr (qm_wr_addr),
      .wr_data (qm_wr_data),
      .rd_en   (qm_rd_en),
      .rd_addr (qm_rd_addr),
      .rd_data (qm_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff    <= SQ_IDLE;
         valid_ff  <= '0;
         lens_ff   <= '{default: '0};
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         seq_ff    <= seq_in;
         valid_ff  <= valid_in;
         lens_ff   <= lens_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
      req_ff  <= req_in;
      cnt_ff  <= cnt_in;
      wcnt_ff <= wcnt_in;
      q_ff    <= q_in;
      pq_ff   <= pq_in;
      pidx_ff <= pidx_in;
      rsp_ff  <= rsp_in;
   end

   assign pid_ext  = EXW'(req_ff.proc_id);
   assign pid_addr = pid_ext[PIW-1:0];
   assign pid_ok   = pid_ext < EXW'(NUM_PROCS);
   assign dev_q    = (req_ff.device == DEV_NONE) ? DEV_KEYBOARD : req_ff.device;
   assign cur_len  = (q_ff == 2'd3) ? '0 : CW'(lens_ff[q_ff]);
   assign cur_st   = st_rd_data[2*PST_W-1:PST_W];
   assign cur_snap = st_rd_data[PST_W-1:0];
   assign init_st  = (req_ff.init_state > PS_EXIT) ? PS_EXIT : req_ff.init_state;
   assign later_valid  = (valid_ff >> pidx_ff) >> 1;
   assign queues_empty = (lens_ff[0] == '0) && (lens_ff[1] == '0) && (lens_ff[2] == '0);

   always_comb begin
      case (pq_ff)
         2'd0:    later_q_empty = (lens_ff[1] == '0) && (lens_ff[2] == '0);
         2'd1:    later_q_empty = (lens_ff[2] == '0);
         default: later_q_empty = 1'b1;
      endcase
   end

   always_comb begin
      case (req_ff.cmd)
         CMD_REQUEST:   new_st = PS_BLOCKED;
         CMD_DISPATCH:  new_st = PS_RUNNING;
         CMD_TIMEOUT:   new_st = PS_READY;
         CMD_SWAP_OUT:  new_st = (cur_st == PS_BLOCKED) ? PS_BLOCKED_SUSP : PS_READY_SUSP;
         CMD_SWAP_IN:   new_st = (cur_st == PS_BLOCKED_SUSP) ? PS_BLOCKED : PS_READY;
         CMD_INTERRUPT: new_st = (cur_st == PS_BLOCKED) ? PS_READY : PS_READY_SUSP;
         CMD_TERMINATE: new_st = PS_EXIT;
         default:       new_st = init_st;
      endcase
   end

   always_comb begin
      seq_in    = seq_ff;
      req_in    = req_ff;
      valid_in  = valid_ff;
      lens_in   = lens_ff;
      cnt_in    = cnt_ff;
      wcnt_in   = wcnt_ff;
      q_in      = q_ff;
      pq_in     = pq_ff;
      pend_in   = 1'b0;
      pidx_in   = pidx_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      st_wr_en   = 1'b0;
      st_wr_addr = pid_addr;
      st_wr_data = {new_st, cur_snap};
      st_rd_en   = 1'b0;
      st_rd_addr = pid_addr;
      qm_wr_en   = 1'b0;
      qm_wr_addr = {dev_q, lens_ff[dev_q][QIW-1:0]};
      qm_wr_data = req_ff.proc_id;
      qm_rd_en   = 1'b0;
      qm_rd_addr = {q_ff, cnt_ff[QIW-1:0]};

      case (seq_ff)
         SQ_IDLE: begin
            if (start && !busy) begin
               req_in = req_item;
               seq_in = SQ_READ;
            end
         end
         SQ_READ: begin
            st_rd_en = 1'b1;
            seq_in   = SQ_EXEC;
         end
         SQ_EXEC: begin
            cnt_in  = '0;
            wcnt_in = '0;
            q_in    = '0;
            seq_in  = req_ff.end_of_line ? SQ_DP : SQ_IDLE;
            if (pid_ok && req_ff.cmd == CMD_INIT) begin
               valid_in[pid_addr] = 1'b1;
               st_wr_en   = 1'b1;
               st_wr_data = {init_st, init_st};
            end else if (pid_ok && valid_ff[pid_addr]) begin
               st_wr_en = 1'b1;
               if (req_ff.cmd == CMD_REQUEST &&
                   CW'(lens_ff[dev_q]) < CW'(QUEUE_DEPTH)) begin
                  qm_wr_en       = 1'b1;
                  lens_in[dev_q] = lens_ff[dev_q] + 1'b1;
               end
               if (req_ff.cmd == CMD_INTERRUPT) begin
                  seq_in = SQ_RM;
               end
            end
         end
         SQ_RM: begin
            // Read entries in order and write back those kept, closing gaps.
            if (cnt_ff < cur_len) begin
               qm_rd_en = 1'b1;
               pend_in  = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
            end
            if (pend_ff && qm_rd_data != req_ff.proc_id) begin
               qm_wr_en   = 1'b1;
               qm_wr_addr = {q_ff, wcnt_ff[QIW-1:0]};
               qm_wr_data = qm_rd_data;
               wcnt_in    = wcnt_ff + 1'b1;
            end
            if (cnt_ff == cur_len && !pend_ff) begin
               lens_in[q_ff] = wcnt_ff[LW-1:0];
               cnt_in  = '0;
               wcnt_in = '0;
               q_in    = q_ff + 1'b1;
               if (q_ff == 2'd2) begin
                  q_in   = '0;
                  seq_in = req_ff.end_of_line ? SQ_DP : SQ_IDLE;
               end
            end
         end
         SQ_DP: begin
            st_rd_addr = cnt_ff[PIW-1:0];
            if (cnt_ff < CW'(NUM_PROCS)) begin
               st_rd_en = 1'b1;
               pend_in  = 1'b1;
               pidx_in  = cnt_ff;
               cnt_in   = cnt_ff + 1'b1;
            end
            if (pend_ff && valid_ff[pidx_ff[PIW-1:0]]) begin
               strobe_in        = 1'b1;
               rsp_in.kind      = KIND_PROC;
               rsp_in.out_proc  = pidx_ff[PID_W-1:0];
               rsp_in.out_state = cur_st;
               rsp_in.changed   = (cur_st != cur_snap);
               rsp_in.last      = (later_valid == '0) && queues_empty;
               st_wr_en   = 1'b1;
               st_wr_addr = pidx_ff[PIW-1:0];
               st_wr_data = {cur_st, cur_st};
            end
            if (cnt_ff == CW'(NUM_PROCS) && !pend_ff) begin
               cnt_in = '0;
               q_in   = '0;
               seq_in = SQ_DQ;
            end
         end
         SQ_DQ: begin
            if (q_ff != 2'd3) begin
               if (cnt_ff < cur_len) begin
                  qm_rd_en = 1'b1;
                  pend_in  = 1'b1;
                  pidx_in  = cnt_ff;
                  pq_in    = q_ff;
                  cnt_in   = cnt_ff + 1'b1;
               end else begin
                  cnt_in = '0;
                  q_in   = q_ff + 1'b1;
               end
            end else if (!pend_ff) begin
               seq_in = SQ_IDLE;
            end
            if (pend_ff) begin
               strobe_in        = 1'b1;
               rsp_in.kind      = pq_ff + 1'b1;
               rsp_in.out_proc  = qm_rd_data;
               rsp_in.out_state = PS_NEW;
               rsp_in.changed   = 1'b0;
               rsp_in.last      = later_q_empty &&
                                  (pidx_ff + 1'b1 == CW'(lens_ff[pq_ff]));
            end
         end
         default: seq_in = SQ_IDLE;
      endcase
   end

   assign busy       = (seq_ff != SQ_IDLE) || strobe_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;
endmodule

// ----- sv/pstq_checker.sv -----
// Port-level checks for the process state table, bound to the top level.
module pstq_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input pstq_pkg::rsp_type rsp_item
);
   import pstq_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !busy && !rsp_strobe)
      else $error("block not idle after reset");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result shown while idle");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.last |=> !rsp_strobe)
      else $error("result follows the final result of a dump");

   a_queue_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.kind != KIND_PROC |-> rsp_item.out_state == PS_NEW
                                                  && !rsp_item.changed)
      else $error("queue entry carries state fields");
endmodule

bind process_state_table_with_io_queues pstq_checker u_pstq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

// ----- verif/tb_top.sv -----
// Testbench for the process state table: directed and random events, checked dumps.
`timescale 1ns / 100ps
module tb_top;
   import pstq_pkg::*;

   localparam int NPROC = 16;
   localparam int QDEPTH = 16;
   localparam int CYCLE_LIMIT = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_item = '0;
   logic rsp_strobe;
   rsp_type rsp_item;

   always #10 clock = ~clock;

   process_state_table_with_io_queues #(.NUM_PROCS(NPROC), .QUEUE_DEPTH(QDEPTH)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   // Predicted machine state.
   logic [PST_W-1:0] m_state [NPROC];
   logic [PST_W-1:0] m_snap [NPROC];
   logic m_valid [NPROC];
   logic [PID_W-1:0] m_queue [3][$];

   req_type pending_events[$];
   rsp_type expected_dump[$];
   int errors = 0;
   int cycles = 0;
   bit stim_done = 0;
   bit hold_for_drain = 0;
   bit drained_once = 0;
   int gap_left = 0;
   int burst_left = 0;

   task automatic report(input string msg);
      errors++;
      $display("mismatch: %s", msg);
   endtask

   function automatic void predict_event(input req_type ev);
      logic [PST_W-1:0] cur;
      int q;
      rsp_type r;
      int first;
      cur = m_state[ev.proc_id];
      if (ev.cmd == CMD_INIT) begin
         m_valid[ev.proc_id] = 1'b1;
         m_state[ev.proc_id] = (ev.init_state > PS_EXIT) ? PS_EXIT : ev.init_state;
         m_snap[ev.proc_id] = m_state[ev.proc_id];
      end else if (m_valid[ev.proc_id]) begin
         case (cmd_type'(ev.cmd))
            CMD_REQUEST: begin
               m_state[ev.proc_id] = PS_BLOCKED;
               q = (ev.device == DEV_NONE) ? 2 : int'(ev.device);
               if (m_queue[q].size() < QDEPTH) m_queue[q].push_back(ev.proc_id);
            end
            CMD_DISPATCH: m_state[ev.proc_id] = PS_RUNNING;
            CMD_TIMEOUT: m_state[ev.proc_id] = PS_READY;
            CMD_SWAP_OUT: m_state[ev.proc_id] =
               (cur == PS_BLOCKED) ? PS_BLOCKED_SUSP : PS_READY_SUSP;
            CMD_SWAP_IN: m_state[ev.proc_id] =
               (cur == PS_BLOCKED_SUSP) ? PS_BLOCKED : PS_READY;
            CMD_INTERRUPT: begin
               m_state[ev.proc_id] = (cur == PS_BLOCKED) ? PS_READY : PS_READY_SUSP;
               for (int k = 0; k < 3; k++)
                  for (int j = m_queue[k].size() - 1; j >= 0; j--)
                     if (m_queue[k][j] == ev.proc_id) m_queue[k].delete(j);
            end
            default: m_state[ev.proc_id] = PS_EXIT;
         endcase
      end
      if (!ev.end_of_line) return;
      first = expected_dump.size();
      for (int i = 0; i < NPROC; i++)
         if (m_valid[i]) begin
            r = '0;
            r.kind = KIND_PROC;
            r.out_proc = i[PID_W-1:0];
            r.out_state = m_state[i];
            r.changed = (m_state[i] != m_snap[i]);
            expected_dump.push_back(r);
            m_snap[i] = m_state[i];
         end
      for (int k = 0; k < 3; k++)
         foreach (m_queue[k][j]) begin
            r = '0;
            r.kind = KIND_W'(k + 1);
            r.out_proc = m_queue[k][j];
            expected_dump.push_back(r);
         end
      if (expected_dump.size() > first) expected_dump[$].last = 1'b1;
   endfunction

   function automatic req_type make_event(input int c, input int p, input int d,
                                         input int s, input bit eol);
      req_type ev;
      ev.cmd = c[CMD_W-1:0];
      ev.proc_id = p[PID_W-1:0];
      ev.device = d[DEV_W-1:0];
      ev.init_state = s[PST_W-1:0];
      ev.end_of_line = eol;
      return ev;
   endfunction

   // Driver: bursts with gaps, one pause until all dumps have drained.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         predict_event(req_item);
         if (pending_events.size() > 0 && burst_left > 0 && !hold_for_drain) begin
            req_item <= pending_events.pop_front();
            burst_left--;
         end else begin
            start <= 1'b0;
            gap_left = $urandom_range(0, 8);
         end
      end else if (!start) begin
         if (hold_for_drain) begin
            if (expected_dump.size() == 0) hold_for_drain = 0;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (pending_events.size() > 0) begin
            if (!drained_once && pending_events.size() <= 200) begin
               hold_for_drain = 1;
               drained_once = 1;
            end
            burst_left = $urandom_range(0, 12);
            req_item <= pending_events.pop_front();
            start <= 1'b1;
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_strobe) begin
         if (expected_dump.size() == 0) begin
            report($sformatf("unexpected result %p", rsp_item));
         end else begin
            rsp_type e;
            e = expected_dump.pop_front();
            if (rsp_item.kind !== e.kind) report($sformatf("kind %0d want %0d",
               rsp_item.kind, e.kind));
            if (rsp_item.out_proc !== e.out_proc) report($sformatf("proc %0d want %0d",
               rsp_item.out_proc, e.out_proc));
            if (rsp_item.out_state !== e.out_state) report($sformatf(
               "state %0d want %0d", rsp_item.out_state, e.out_state));
            if (rsp_item.changed !== e.changed) report("changed flag differs");
            if (rsp_item.last !== e.last) report("last flag differs");
         end
      end
   end

   initial begin
      int n_valid;
      int pid;
      for (int i = 0; i < NPROC; i++) begin
         m_valid[i] = 0;
         m_state[i] = PS_NEW;
         m_snap[i] = PS_NEW;
      end
      // Directed: unknown process, all init states, every event, device 3, full queue.
      pending_events.push_back(make_event(CMD_DISPATCH, 5, 0, 0, 1));
      for (int s = 0; s < 8; s++) pending_events.push_back(make_event(CMD_INIT, s, 0, s, 0));
      pending_events.push_back(make_event(CMD_INIT, 15, 0, 1, 1));
      pending_events.push_back(make_event(CMD_REQUEST, 15, 3, 0, 0));
      pending_events.push_back(make_event(CMD_REQUEST, 15, 0, 0, 0));
      pending_events.push_back(make_event(CMD_REQUEST, 3, 1, 0, 1));
      pending_events.push_back(make_event(CMD_SWAP_OUT, 15, 0, 0, 0));
      pending_events.push_back(make_event(CMD_SWAP_IN, 15, 0, 0, 0));
      pending_events.push_back(make_event(CMD_SWAP_OUT, 1, 0, 0, 0));
      pending_events.push_back(make_event(CMD_SWAP_IN, 1, 0, 0, 1));
      pending_events.push_back(make_event(CMD_TIMEOUT, 2, 0, 0, 0));
      pending_events.push_back(make_event(CMD_INTERRUPT, 15, 0, 0, 0));
      pending_events.push_back(make_event(CMD_INTERRUPT, 1, 0, 0, 0));
      pending_events.push_back(make_event(CMD_TERMINATE, 0, 0, 0, 1));
      for (int k = 0; k < 17; k++)
         pending_events.push_back(make_event(CMD_REQUEST, k % 2 ? 4 : 6, 2, 0, k == 16));
      pending_events.push_back(make_event(CMD_INTERRUPT, 4, 0, 0, 1));
      // Random: mostly events on known processes, with dumps every few items.
      for (int k = 0; k < 390; k++) begin
         pid = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 11);
         pending_events.push_back(make_event($urandom_range(0, 7), pid, $urandom_range(0, 3),
            $urandom_range(0, 7), $urandom_range(0, 4) == 0));
      end
      pending_events.push_back(make_event(CMD_TIMEOUT, 0, 0, 0, 1));
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (pending_events.size() == 0 && !start);
      wait (expected_dump.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   always @(posedge clock)
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
endmodule
